>>> rtl/core/swstat_pkg.sv
// ----------------------------------------------------------------------------
// swstat_pkg
// Shared constants, codes and types of the sliding window statistics block.
// ----------------------------------------------------------------------------
package swstat_pkg;

   localparam int WINDOW      = 8;
   localparam int SAMPLE_BITS = 16;

   localparam int CFG_W  = 4;                                   // config register width
   localparam int OCNT_W = 4;                                   // sample_count field width
   localparam int CNT_W  = $clog2(WINDOW + 1);                  // 0..WINDOW
   localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;   // window position
   localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);        // window sum
   localparam int DVS_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;     // divisor
   localparam int RNG_W  = (CFG_W + 1 > CNT_W) ? CFG_W + 1 : CNT_W;
   localparam int DCNT_W = $clog2(SUM_W);                       // divider step count

   localparam int REQ_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_BITS   = 6 * SAMPLE_BITS + OCNT_W + 1;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // configuration register indexes
   localparam logic CSR_AVG_START = 1'b0;
   localparam logic CSR_AVG_LEN   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MEAN_LOAD,
      ST_MEAN_RUN,
      ST_RANGE_LOAD,
      ST_RANGE_RUN,
      ST_PUBLISH
   } state_type;

   typedef struct packed {
      logic store;       // take in the sample, reset accumulators
      logic scan;        // process one window position
      logic init_mean;   // load divider with window sum / count
      logic take_mean;   // keep divider quotient as mean
      logic init_range;  // load divider with sub-range sum / length
      logic div_step;    // one restoring division step
      logic publish;     // load output register
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic div_last;
   } sts_type;

endpackage

>>> rtl/core/swstat_ctrl.sv
// ----------------------------------------------------------------------------
// swstat_ctrl
// Sequencer: store, scan, two divisions, publish; owns the handshakes.
// ----------------------------------------------------------------------------
module swstat_ctrl
   import swstat_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd,
   input  sts_type sts
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:       if (req_tvalid) state_in = ST_SCAN;
         ST_SCAN:       if (sts.scan_last) state_in = ST_MEAN_LOAD;
         ST_MEAN_LOAD:  state_in = ST_MEAN_RUN;
         ST_MEAN_RUN:   if (sts.div_last) state_in = ST_RANGE_LOAD;
         ST_RANGE_LOAD: state_in = ST_RANGE_RUN;
         ST_RANGE_RUN:  if (sts.div_last) state_in = ST_PUBLISH;
         ST_PUBLISH:    if (out_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:       cmd.store = req_tvalid;
         ST_SCAN:       cmd.scan = 1'b1;
         ST_MEAN_LOAD:  cmd.init_mean = 1'b1;
         ST_MEAN_RUN:   cmd.div_step = 1'b1;
         ST_RANGE_LOAD: begin
            cmd.take_mean  = 1'b1;
            cmd.init_range = 1'b1;
         end
         ST_RANGE_RUN:  cmd.div_step = 1'b1;
         ST_PUBLISH:    cmd.publish = out_free;
         default:       cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.publish) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/core/swstat_dp.sv
// ----------------------------------------------------------------------------
// swstat_dp
// Window store, scan accumulators, rank-based median, shared divider, output.
// ----------------------------------------------------------------------------
module swstat_dp
   import swstat_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic                          csr_addr,
   input  logic [CFG_W-1:0]              csr_wdata,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  cmd_type                       cmd,
   output sts_type                       sts,
   output logic [RSP_BITS-1:0]           rsp_bits
);

   logic [CFG_W-1:0] avg_start_ff, avg_len_ff;
   logic [CNT_W-1:0] fill_ff;
   logic signed [SAMPLE_BITS-1:0] win_ff [WINDOW];

   logic [IDX_W-1:0] idx_ff;
   logic signed [SAMPLE_BITS-1:0] latest_ff, min_ff, max_ff, lo_ff, hi_ff;
   logic signed [SUM_W-1:0] sum_ff, rsum_ff;

   logic [SUM_W-1:0] q_ff;
   logic [DVS_W-1:0] dvs_ff, rem_ff;
   logic             neg_ff;
   logic [DCNT_W-1:0] dcnt_ff;
   logic signed [SAMPLE_BITS-1:0] mean_ff;

   logic signed [SAMPLE_BITS-1:0] o_latest_ff, o_min_ff, o_max_ff, o_mean_ff;
   logic signed [SAMPLE_BITS-1:0] o_med_ff, o_ravg_ff;
   logic [OCNT_W-1:0] o_cnt_ff;
   logic              o_rvalid_ff;

   // ---- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         avg_start_ff <= CFG_W'(1);
         avg_len_ff   <= CFG_W'(8);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_AVG_START: avg_start_ff <= csr_wdata;
            CSR_AVG_LEN:   avg_len_ff   <= csr_wdata;
            default:       avg_len_ff   <= avg_len_ff;
         endcase
      end
   end

   // ---- sub-range bounds
   logic [RNG_W-1:0] rng_last, pos;
   logic             rng_valid, in_rng;
   assign rng_last  = RNG_W'(avg_start_ff) + RNG_W'(avg_len_ff) - RNG_W'(1);
   assign rng_valid = (avg_start_ff != '0) && (avg_len_ff != '0) &&
                      (rng_last <= RNG_W'(fill_ff));
   assign pos       = RNG_W'(idx_ff) + RNG_W'(1);
   assign in_rng    = (pos >= RNG_W'(avg_start_ff)) && (pos <= rng_last);

   // ---- window store and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (cmd.store && fill_ff != CNT_W'(WINDOW)) begin
         fill_ff <= fill_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         if (fill_ff == CNT_W'(WINDOW)) begin
            for (int i = 0; i < WINDOW - 1; i++) win_ff[i] <= win_ff[i+1];
            win_ff[WINDOW-1] <= sample;
         end else begin
            win_ff[fill_ff[IDX_W-1:0]] <= sample;
         end
      end
   end

   // ---- rank of the scanned element (ties broken by position)
   logic signed [SAMPLE_BITS-1:0] v;
   logic [CNT_W-1:0] rank;
   logic [CNT_W-1:0] mid_lo, mid_hi;
   assign v      = win_ff[idx_ff];
   assign mid_lo = (fill_ff - CNT_W'(1)) >> 1;
   assign mid_hi = fill_ff >> 1;

   always_comb begin
      rank = '0;
      for (int j = 0; j < WINDOW; j++) begin
         if ((CNT_W'(j) < fill_ff) &&
             ((win_ff[j] < v) || ((win_ff[j] == v) && (IDX_W'(j) < idx_ff))))
            rank = rank + CNT_W'(1);
      end
   end

   assign sts.scan_last = (CNT_W'(idx_ff) == fill_ff - CNT_W'(1));

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         idx_ff    <= '0;
         sum_ff    <= '0;
         rsum_ff   <= '0;
         latest_ff <= sample;
      end else if (cmd.scan) begin
         idx_ff <= idx_ff + IDX_W'(1);
         sum_ff <= sum_ff + SUM_W'(v);
         if (in_rng) rsum_ff <= rsum_ff + SUM_W'(v);
         if (idx_ff == '0 || v < min_ff) min_ff <= v;
         if (idx_ff == '0 || v > max_ff) max_ff <= v;
         if (rank == mid_lo) lo_ff <= v;
         if (rank == mid_hi) hi_ff <= v;
      end
   end

   // ---- shared restoring divider on magnitudes
   logic signed [SUM_W-1:0] dvd;
   logic [DVS_W:0]          rem_sh, diff;
   logic signed [SAMPLE_BITS-1:0] quo;
   assign dvd    = cmd.init_mean ? sum_ff : rsum_ff;
   assign rem_sh = {rem_ff, q_ff[SUM_W-1]};
   assign diff   = rem_sh - {1'b0, dvs_ff};
   assign quo    = neg_ff ? -SAMPLE_BITS'(q_ff) : SAMPLE_BITS'(q_ff);
   assign sts.div_last = (dcnt_ff == DCNT_W'(SUM_W - 1));

   always_ff @(posedge clock) begin
      if (cmd.init_mean || cmd.init_range) begin
         neg_ff  <= dvd[SUM_W-1];
         q_ff    <= dvd[SUM_W-1] ? -dvd : dvd;
         dvs_ff  <= cmd.init_mean ? DVS_W'(fill_ff) : DVS_W'(avg_len_ff);
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff + DCNT_W'(1);
         if (!diff[DVS_W]) begin
            rem_ff <= diff[DVS_W-1:0];
            q_ff   <= {q_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[DVS_W-1:0];
            q_ff   <= {q_ff[SUM_W-2:0], 1'b0};
         end
      end
      if (cmd.take_mean) mean_ff <= quo;
   end

   // ---- output register
   logic signed [SAMPLE_BITS:0] mid_sum;
   assign mid_sum = (SAMPLE_BITS+1)'(lo_ff) + (SAMPLE_BITS+1)'(hi_ff);

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         o_latest_ff <= latest_ff;
         o_cnt_ff    <= OCNT_W'(fill_ff);
         o_min_ff    <= min_ff;
         o_max_ff    <= max_ff;
         o_mean_ff   <= mean_ff;
         o_med_ff    <= SAMPLE_BITS'(mid_sum >>> 1);
         o_ravg_ff   <= rng_valid ? quo : '0;
         o_rvalid_ff <= rng_valid;
      end
   end

   assign rsp_bits = {o_rvalid_ff, o_ravg_ff, o_med_ff, o_mean_ff,
                      o_max_ff, o_min_ff, o_cnt_ff, o_latest_ff};

endmodule

>>> rtl/core/sliding_window_statistics.sv
// ----------------------------------------------------------------------------
// sliding_window_statistics
// Running min, max, mean, median and sub-range average over a sample window.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata: sample
//  rsp     | out | rsp_tvalid/tready    | tdata: latest .. range_valid
//  csr     | in  | csr_we (no wait)     | csr_addr index, csr_wdata value
//
//  One transaction stores the sample, scans each held sample (1..WINDOW
//  of them), then runs two divisions on the shared bit-serial divider,
//  then publishes. A result waits in the output register while the next
//  sample is taken; publish stalls only while that register still holds
//  an unaccepted result.
//  Reset (synchronous) empties the window and sets avg_start 1, avg_len 8.
// ----------------------------------------------------------------------------
module sliding_window_statistics
   import swstat_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // input samples
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [15:0] sample
   // results
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [15:0] latest, [19:16] sample_count, [35:20] minimum, [51:36] maximum,
   // [67:52] mean, [83:68] median, [99:84] range_avg, [100] range_valid
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // configuration writes
   input  logic                  csr_we,
   input  logic                  csr_addr,
   input  logic [CFG_W-1:0]      csr_wdata
);

   cmd_type cmd;
   sts_type sts;
   logic [RSP_BITS-1:0] rsp_bits;

   swstat_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   swstat_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .sample    (req_tdata[SAMPLE_BITS-1:0]),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_bits  (rsp_bits)
   );

   // pad to whole bytes
   assign rsp_tdata = RSP_DATA_W'(rsp_bits);

endmodule

>>> tb/sv/sliding_window_statistics_checker.sv
// ----------------------------------------------------------------------------
// sliding_window_statistics_checker
// Watches the sample, result and register channels of the window statistics
// block, keeps its own copy of the window and registers, predicts each result
// and compares it field by field.
// ----------------------------------------------------------------------------
module sliding_window_statistics_checker
   import swstat_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic                  csr_addr,
   input  logic [CFG_W-1:0]      csr_wdata,
   output int                    fail_count,
   output int                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                   range_valid;
      logic [SAMPLE_BITS-1:0] range_avg;
      logic [SAMPLE_BITS-1:0] median;
      logic [SAMPLE_BITS-1:0] mean;
      logic [SAMPLE_BITS-1:0] maximum;
      logic [SAMPLE_BITS-1:0] minimum;
      logic [OCNT_W-1:0]      sample_count;
      logic [SAMPLE_BITS-1:0] latest;
   } stats_t;

   longint  win[WINDOW];
   int      held;
   int      start_pos, run_len;
   stats_t  stats_q[$];

   assign pending = stats_q.size();

   function automatic longint trunc_div(longint s, longint d);
      return (s < 0) ? -((-s) / d) : s / d;
   endfunction

   function automatic stats_t window_stats(longint s);
      stats_t r;
      longint srt[WINDOW];
      longint mn, mx, sum, med, rs, v;
      int j;
      if (held >= WINDOW) begin
         for (int i = 1; i < WINDOW; i++) win[i-1] = win[i];
         win[WINDOW-1] = s;
      end else begin
         win[held] = s;
         held++;
      end
      mn = win[0]; mx = win[0]; sum = 0;
      for (int i = 0; i < held; i++) begin
         if (win[i] < mn) mn = win[i];
         if (win[i] > mx) mx = win[i];
         sum += win[i];
         srt[i] = win[i];
      end
      for (int i = 1; i < held; i++) begin
         v = srt[i]; j = i;
         while (j > 0 && srt[j-1] > v) begin
            srt[j] = srt[j-1]; j--;
         end
         srt[j] = v;
      end
      if (held % 2 == 0) begin
         med = srt[held/2] + srt[held/2-1];
         med = (med < 0) ? -((-med + 1) / 2) : med / 2;
      end else begin
         med = srt[(held-1)/2];
      end
      r.latest       = s[SAMPLE_BITS-1:0];
      r.sample_count = held[OCNT_W-1:0];
      r.minimum      = mn[SAMPLE_BITS-1:0];
      r.maximum      = mx[SAMPLE_BITS-1:0];
      v              = trunc_div(sum, held);
      r.mean         = v[SAMPLE_BITS-1:0];
      r.median       = med[SAMPLE_BITS-1:0];
      r.range_avg    = '0;
      r.range_valid  = 1'b0;
      if (start_pos >= 1 && run_len >= 1 && start_pos + run_len - 1 <= held) begin
         rs = 0;
         for (int i = start_pos - 1; i < start_pos + run_len - 1; i++) rs += win[i];
         v = trunc_div(rs, run_len);
         r.range_avg   = v[SAMPLE_BITS-1:0];
         r.range_valid = 1'b1;
      end
      return r;
   endfunction

   task automatic compare(string name, longint e, longint a);
      if (e != a) begin
         $error("%s mismatch: expected %0h, actual %0h", name, e, a);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      stats_t got, want;
      if (reset) begin
         held = 0; start_pos = 1; run_len = 8;
         stats_q.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            if (csr_addr == CSR_AVG_START) start_pos = int'(csr_wdata);
            else                           run_len   = int'(csr_wdata);
         end
         if (req_tvalid && req_tready)
            stats_q.push_back(window_stats(longint'(signed'(req_tdata[SAMPLE_BITS-1:0]))));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[RSP_BITS-1:0];
            if (stats_q.size() == 0) begin
               $error("result transaction with no expected result");
               fail_count++;
            end else begin
               want = stats_q.pop_front();
               compare("latest",       want.latest,       got.latest);
               compare("sample_count", want.sample_count, got.sample_count);
               compare("minimum",      want.minimum,      got.minimum);
               compare("maximum",      want.maximum,      got.maximum);
               compare("mean",         want.mean,         got.mean);
               compare("median",       want.median,       got.median);
               compare("range_avg",    want.range_avg,    got.range_avg);
               compare("range_valid",  want.range_valid,  got.range_valid);
            end
         end
      end
   end

endmodule

>>> tb/sv/sliding_window_statistics_tb.sv
// ----------------------------------------------------------------------------
// sliding_window_statistics_tb
// Drives samples and register writes into the window statistics block under
// random bursts and result stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module sliding_window_statistics_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import swstat_pkg::*;

   localparam int RANDOM_ITEMS = 600;
   localparam int CYCLE_LIMIT  = 400000;   // ~640 items with result stalls, several times over

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic                  csr_addr = 1'b0;
   logic [CFG_W-1:0]      csr_wdata = '0;
   int                    fail_count, pending;
   int                    cycles = 0;
   bit                    stall_on = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   sliding_window_statistics dut (.*);
   sliding_window_statistics_checker checker_i (.*);

   // timeout guard
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver stalls: alternating stretches of random and no back-pressure
   always @(negedge clock) begin
      if (cycles % 500 == 0) stall_on <= ~stall_on;
      rsp_tready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
   end

   // one sample transaction; tvalid stays high for a following sample
   task automatic send_sample(logic [15:0] value);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(value);
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_burst(int n);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 5))
            0:       send_sample(16'h8000);
            1:       send_sample(16'h7fff);
            2:       send_sample(16'($urandom_range(0, 16) - 8));
            default: send_sample(16'($urandom));
         endcase
      end
      req_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clock);
   endtask

   // stop sending, wait for all results, then the block's idle latency
   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   // write enable stays high across back-to-back writes
   task automatic csr_write(logic addr, logic [CFG_W-1:0] value);
      csr_we <= 1'b1; csr_addr <= addr; csr_wdata <= value;
      @(negedge clock);
   endtask

   task automatic set_range(logic [CFG_W-1:0] first, logic [CFG_W-1:0] len);
      drain();
      csr_write(CSR_AVG_START, first);
      csr_write(CSR_AVG_LEN, len);
      csr_we <= 1'b0;
   endtask

   initial begin
      int sent;
      int next_cfg;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      // directed: extremes while filling, then rolling window
      send_sample(16'h7fff);
      send_sample(16'h8000);
      send_sample(16'hffff);
      send_sample(16'h0001);
      send_sample(16'h8000);
      send_sample(16'h8000);
      send_sample(16'h7fff);
      send_sample(16'h7fff);
      send_sample(16'hfffd);
      send_sample(16'h0000);
      // zero start and zero length: always invalid
      set_range(4'd0, 4'd3);
      send_sample(16'h1234);
      set_range(4'd2, 4'd0);
      send_sample(16'hedcb);
      // range past the window end at the full 4-bit extremes, then the last position
      set_range(4'd15, 4'd15);
      send_sample(16'h0005);
      set_range(4'd8, 4'd1);
      send_sample(16'hfff9);
      // random phases through several register settings
      sent = 0;
      next_cfg = 0;
      while (sent < RANDOM_ITEMS) begin
         int n;
         if (sent >= next_cfg) begin
            set_range(4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)));
            next_cfg += 100;
         end
         n = $urandom_range(1, 12);
         send_burst(n);
         sent += n;
      end
      set_range(4'd1, 4'd8);
      send_burst(20);
      drain();
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/swstat_pkg.sv
rtl/core/swstat_ctrl.sv
rtl/core/swstat_dp.sv
rtl/core/sliding_window_statistics.sv
tb/sv/sliding_window_statistics_checker.sv
tb/sv/sliding_window_statistics_tb.sv
